// ===== src/opm_pkg.sv =====
// shared constants and state codes for the optimal merge pattern block
package opm_pkg;

	localparam int MAX_TREES = 64;
	localparam int IN_W      = 16;
	localparam int WT_W      = 22;
	localparam int ADDR_W    = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
	localparam int CNT_W     = $clog2(MAX_TREES + 1);

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_FIX  = 3'd2;
	localparam logic [2:0] ST_INS  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

endpackage

// ===== src/opm_ram.sv =====
// generic single-clock ram, one write port and one registered read port
module opm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/optimal_merge_pattern_core.sv =====
// optimal merge pattern engine: weight load, min extraction and sum reinsert over one ram
//
//  channel   signals                                        direction
//  in        in_valid in_ready weight is_last               request in
//  out       out_valid out_ready first_weight second_weight  request out
//            merged_weight final_merge overflow_dropped
//
// a weight that is not last is taken without leaving the load state, so loading goes on.
// each merge runs two linear min scans (one when a lone weight is left)
// through the store ram (one read per cycle, registered read data) plus write-backs.
// reset clears the count, the dropped flag and the output valid; the ram is not cleared.
// a waiting result in the output register stalls only the emit of the next merge, not its scans or loading.
module optimal_merge_pattern_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [opm_pkg::IN_W-1:0]     weight,
	input  logic                         is_last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [opm_pkg::WT_W-1:0]     first_weight,
	output logic [opm_pkg::WT_W-1:0]     second_weight,
	output logic [opm_pkg::WT_W-1:0]     merged_weight,
	output logic                         final_merge,
	output logic                         overflow_dropped
);

	import opm_pkg::*;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              dropped_q;
	logic [CNT_W-1:0]  addr_q;
	logic              take_q;
	logic              vld_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic [WT_W-1:0]   best_q;
	logic [ADDR_W-1:0] best_idx_q;
	logic [WT_W-1:0]   last_q;
	logic [WT_W-1:0]   a_q;
	logic [WT_W-1:0]   b_q;
	logic              out_valid_q;

	logic              in_acc;
	logic              issue;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [WT_W-1:0]   wdata;
	logic [WT_W-1:0]   rdata;
	logic [WT_W-1:0]   sum;
	logic              out_free;
	logic              room;

	assign in_ready = (state_q == ST_LOAD);
	assign in_acc   = in_valid && in_ready;
	assign room     = (cnt_q < CNT_W'(MAX_TREES));
	assign issue    = (state_q == ST_SCAN) && (addr_q < cnt_q);
	assign sum      = a_q + b_q;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[ADDR_W-1:0];
		wdata = WT_W'(weight);
		case (state_q)
			ST_LOAD: begin
				we = in_acc && room;
			end
			ST_FIX: begin
				// swap-remove: the last entry fills the hole left by the minimum
				we    = 1'b1;
				waddr = best_idx_q;
				wdata = last_q;
			end
			ST_INS: begin
				we    = 1'b1;
				wdata = sum;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	opm_ram #(
		.WIDTH(WT_W),
		.DEPTH(MAX_TREES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (addr_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	// datapath registers of the scan, the merge pair and the output
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q[ADDR_W-1:0];
		if (state_q == ST_SCAN && vld_s1) begin
			if (idx_s1 == '0 || rdata < best_q) begin
				best_q     <= rdata;
				best_idx_q <= idx_s1;
			end
			last_q <= rdata;
		end
		if (state_q == ST_FIX) begin
			if (!take_q) begin
				a_q <= best_q;
				b_q <= '0;
			end else begin
				b_q <= best_q;
			end
		end
		if (state_q == ST_EMIT && out_free) begin
			first_weight     <= a_q;
			second_weight    <= b_q;
			merged_weight    <= sum;
			final_merge      <= (cnt_q == CNT_W'(1));
			overflow_dropped <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			dropped_q   <= 1'b0;
			addr_q      <= '0;
			take_q      <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (room) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							dropped_q <= 1'b1;
						end
						if (is_last) begin
							state_q <= ST_SCAN;
							addr_q  <= '0;
							take_q  <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						addr_q <= addr_q + 1'b1;
					end
					if (vld_s1 && CNT_W'(idx_s1) == cnt_q - 1'b1) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					cnt_q <= cnt_q - 1'b1;
					if (!take_q && cnt_q != CNT_W'(1)) begin
						state_q <= ST_SCAN;
						addr_q  <= '0;
						take_q  <= 1'b1;
					end else begin
						// second minimum found, or a lone weight that pairs with zero
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (cnt_q == CNT_W'(1)) begin
							cnt_q     <= '0;
							dropped_q <= 1'b0;
							state_q   <= ST_LOAD;
						end else begin
							state_q <= ST_SCAN;
							addr_q  <= '0;
							take_q  <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
